// ===== design/nmeafx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmeafx_pkg
// Shared types and constants for the NMEA fix extractor.
// ----------------------------------------------------------------------------
package nmeafx_pkg;

  localparam int unsigned AltitudeChars = 8;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [7:0] ChG      = 8'h47;
  localparam logic [7:0] ChR      = 8'h52;
  localparam logic [7:0] ChM      = 8'h4d;
  localparam logic [7:0] ChC      = 8'h43;
  localparam logic [7:0] ChA      = 8'h41;
  localparam logic [7:0] ChS      = 8'h53;
  localparam logic [7:0] ChN      = 8'h4e;
  localparam logic [7:0] ChE      = 8'h45;
  localparam logic [7:0] ChV      = 8'h56;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChComma  = 8'h2c;

  localparam logic [47:0] Zeros6 = 48'h303030303030;
  localparam logic [63:0] Zeros8 = 64'h3030303030303030;

  localparam logic CfgTimeoutLimit = 1'b0;
  localparam logic CfgRejectYear   = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_RMC  = 2'd1,
    KIND_GGA  = 2'd2,
    KIND_GSA  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_HUNT_RMC = 2'd0,
    PH_WANT_GGA = 2'd1,
    PH_WANT_GSA = 2'd2
  } phase_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
    logic       is_dollar;
    logic       is_comma;
    logic       is_digit;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

// ===== design/nmeafx_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmeafx_front
// Accepts items, classifies bytes and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module nmeafx_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   mode_i,
  input  logic [7:0]             rx_byte_i,
  output nmeafx_pkg::queue_head_t head_o,
  input  logic                   pop_i
);

  nmeafx_pkg::item_t entry_q [nmeafx_pkg::QueueDepth];
  nmeafx_pkg::item_t new_item;
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;

  always_comb begin
    new_item.mode      = mode_i;
    new_item.rx_byte   = rx_byte_i;
    new_item.is_dollar = (rx_byte_i == nmeafx_pkg::ChDollar);
    new_item.is_comma  = (rx_byte_i == nmeafx_pkg::ChComma);
    new_item.is_digit  = (rx_byte_i >= 8'h30) && (rx_byte_i <= 8'h39);
  end

  assign in_stall = (count_q == 2'(nmeafx_pkg::QueueDepth));
  assign push     = in_valid && !in_stall;

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

// ===== design/nmeafx_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmeafx_back
// Parses queued items field by field and registers the fix and tick records.
// ----------------------------------------------------------------------------
module nmeafx_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we,
  input  logic                    cfg_idx,
  input  logic [6:0]              cfg_data,
  input  nmeafx_pkg::queue_head_t head_i,
  output logic                    pop_o,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [35:0]             time_bcd_o,
  output logic [23:0]             date_bcd_o,
  output logic [47:0]             speed_text_o,
  output logic [47:0]             pdop_text_o,
  output logic [31:0]             latitude_bcd_o,
  output logic [35:0]             longitude_bcd_o,
  output logic                    is_north_o,
  output logic                    is_east_o,
  output logic [63:0]             altitude_text_o,
  output logic                    fix_valid_o,
  output logic                    time_is_new_o,
  output logic                    timed_out_o
);

  nmeafx_pkg::phase_e phase_q, phase_d;
  nmeafx_pkg::kind_e  kind_q, kind_d;
  logic [2:0]  hpos_q, hpos_d;
  logic [4:0]  comma_q, comma_d;
  logic [3:0]  cif_q, cif_d;
  logic [35:0] time_q, time_d;
  logic [23:0] date_q, date_d;
  logic [7:0]  status_q, status_d;
  logic [47:0] speed_q, speed_d;
  logic [31:0] lat_q, lat_d;
  logic [35:0] lon_q, lon_d;
  logic        north_q, north_d, east_q, east_d;
  logic [63:0] alt_q, alt_d;
  logic [47:0] pdop_q, pdop_d;
  logic        bad_q, bad_d, fix_seen_q, fix_seen_d, tg_q, tg_d;
  logic [3:0]  idle_q, idle_d;
  logic [3:0]  tlimit_q;
  logic [6:0]  ryear_q;

  logic        ov_q, ov_d;
  logic [35:0] o_time_q, o_time_d;
  logic [23:0] o_date_q, o_date_d;
  logic [47:0] o_speed_q, o_speed_d, o_pdop_q, o_pdop_d;
  logic [31:0] o_lat_q, o_lat_d;
  logic [35:0] o_lon_q, o_lon_d;
  logic        o_n_q, o_n_d, o_e_q, o_e_d, o_fv_q, o_fv_d, o_tn_q, o_tn_d, o_to_q, o_to_d;
  logic [63:0] o_alt_q, o_alt_d;

  nmeafx_pkg::item_t it;
  logic [7:0] c;
  logic [3:0] dig, k, d;
  logic [4:0] cnew;
  logic [7:0] year;
  logic       rejected, valid_fix, emit, tick, to;

  assign it    = head_i.item;
  assign c     = it.rx_byte;
  assign pop_o = head_i.valid && (!ov_q || !out_stall);

  always_comb begin
    phase_d = phase_q;  kind_d = kind_q;  hpos_d = hpos_q;  comma_d = comma_q;
    cif_d = cif_q;  time_d = time_q;  date_d = date_q;  status_d = status_q;
    speed_d = speed_q;  lat_d = lat_q;  lon_d = lon_q;  north_d = north_q;
    east_d = east_q;  alt_d = alt_q;  pdop_d = pdop_q;  bad_d = bad_q;
    fix_seen_d = fix_seen_q;  tg_d = tg_q;  idle_d = idle_q;
    emit = 1'b0;  tick = 1'b0;  to = 1'b0;
    dig = it.is_digit ? c[3:0] : 4'd0;
    k = cif_q;
    d = 4'd0;
    cnew = (comma_q != 5'd31) ? comma_q + 5'd1 : comma_q;
    year = 8'(date_q[7:4]) * 8'd10 + 8'(date_q[3:0]);
    rejected = (year == {1'b0, ryear_q});
    valid_fix = 1'b0;
    if (pop_o) begin
      if (it.mode) begin
        tick = 1'b1;
        if (fix_seen_q) idle_d = 4'd0;
        else if (idle_q != 4'd15) idle_d = idle_q + 4'd1;
        fix_seen_d = 1'b0;
        to = (idle_d >= tlimit_q);
        if (to) status_d = nmeafx_pkg::ChV;
      end else if (it.is_dollar) begin
        hpos_d = 3'd1;  kind_d = nmeafx_pkg::KIND_NONE;
        comma_d = 5'd0;  cif_d = 4'd0;  tg_d = 1'b0;
      end else if (hpos_q != 3'd0) begin
        unique case (hpos_q)
          3'd1: tg_d = (c == nmeafx_pkg::ChG);
          3'd3: begin
            if (c == nmeafx_pkg::ChR && tg_q) kind_d = nmeafx_pkg::KIND_RMC;
            else if (c == nmeafx_pkg::ChG)
              kind_d = tg_q ? nmeafx_pkg::KIND_GGA : nmeafx_pkg::KIND_GSA;
            else kind_d = nmeafx_pkg::KIND_NONE;
          end
          3'd4: begin
            unique case (kind_q)
              nmeafx_pkg::KIND_RMC:
                if (c != nmeafx_pkg::ChM) kind_d = nmeafx_pkg::KIND_NONE;
              nmeafx_pkg::KIND_GGA: begin
                if (c == nmeafx_pkg::ChS) kind_d = nmeafx_pkg::KIND_GSA;
                else if (c != nmeafx_pkg::ChG) kind_d = nmeafx_pkg::KIND_NONE;
              end
              nmeafx_pkg::KIND_GSA:
                if (c != nmeafx_pkg::ChS) kind_d = nmeafx_pkg::KIND_NONE;
              default: ;
            endcase
          end
          3'd5: begin
            if (kind_q == nmeafx_pkg::KIND_RMC) begin
              if (c != nmeafx_pkg::ChC) kind_d = nmeafx_pkg::KIND_NONE;
            end else if (c != nmeafx_pkg::ChA) kind_d = nmeafx_pkg::KIND_NONE;
          end
          default: ;
        endcase
        if (hpos_q >= 3'd5) begin
          hpos_d = 3'd0;
          unique case (kind_d)
            nmeafx_pkg::KIND_RMC: begin
              phase_d = nmeafx_pkg::PH_WANT_GGA;
              status_d = nmeafx_pkg::ChV;
            end
            nmeafx_pkg::KIND_GGA: begin
              if (phase_q == nmeafx_pkg::PH_HUNT_RMC) kind_d = nmeafx_pkg::KIND_NONE;
              else begin
                phase_d = nmeafx_pkg::PH_WANT_GGA;
                bad_d = 1'b0;
              end
            end
            nmeafx_pkg::KIND_GSA:
              if (phase_q != nmeafx_pkg::PH_WANT_GSA) kind_d = nmeafx_pkg::KIND_NONE;
            default: ;
          endcase
        end else begin
          hpos_d = hpos_q + 3'd1;
        end
      end else if (kind_q == nmeafx_pkg::KIND_NONE) begin
      end else if (it.is_comma) begin
        if (kind_q == nmeafx_pkg::KIND_GGA) begin
          if (comma_q == 5'd2 && cif_q < 4'd9) bad_d = 1'b1;
          if (comma_q == 5'd4 && cif_q < 4'd10) bad_d = 1'b1;
        end
        comma_d = cnew;
        cif_d = 4'd0;
        unique case (kind_q)
          nmeafx_pkg::KIND_RMC: begin
            if (cnew == 5'd1) time_d = '0;
            else if (cnew == 5'd2) status_d = nmeafx_pkg::ChV;
            else if (cnew == 5'd7) speed_d = nmeafx_pkg::Zeros6;
            else if (cnew == 5'd9) date_d = '0;
          end
          nmeafx_pkg::KIND_GGA: begin
            if (cnew == 5'd2) lat_d = '0;
            else if (cnew == 5'd3) north_d = 1'b0;
            else if (cnew == 5'd4) lon_d = '0;
            else if (cnew == 5'd5) east_d = 1'b0;
            else if (cnew == 5'd9) alt_d = nmeafx_pkg::Zeros8;
            else if (cnew == 5'd14) begin
              phase_d = nmeafx_pkg::PH_WANT_GSA;
              kind_d = nmeafx_pkg::KIND_NONE;
            end
          end
          nmeafx_pkg::KIND_GSA: begin
            if (cnew == 5'd15) pdop_d = nmeafx_pkg::Zeros6;
            else if (cnew == 5'd16) begin
              kind_d = nmeafx_pkg::KIND_NONE;
              phase_d = nmeafx_pkg::PH_HUNT_RMC;
              if (cif_q != 4'd0) begin
                emit = 1'b1;
                fix_seen_d = 1'b1;
                idle_d = 4'd0;
              end
            end
          end
          default: ;
        endcase
      end else begin
        if (cif_q != 4'd15) cif_d = cif_q + 4'd1;
        unique case (kind_q)
          nmeafx_pkg::KIND_RMC: begin
            if (comma_q == 5'd1 && k < 4'd10 && k != 4'd6) begin
              d = (k < 4'd6) ? k : k - 4'd1;
              time_d[(4'd8 - d) * 4 +: 4] = time_q[(4'd8 - d) * 4 +: 4] | dig;
            end else if (comma_q == 5'd2 && k == 4'd0) begin
              status_d = c;
            end else if (comma_q == 5'd7 && k < 4'd6) begin
              speed_d[(4'd5 - k) * 8 +: 8] = c;
            end else if (comma_q == 5'd9 && k < 4'd6) begin
              date_d[(4'd5 - k) * 4 +: 4] = date_q[(4'd5 - k) * 4 +: 4] | dig;
            end
          end
          nmeafx_pkg::KIND_GGA: begin
            if (comma_q == 5'd2 && k < 4'd9 && k != 4'd4) begin
              d = (k < 4'd4) ? k : k - 4'd1;
              lat_d[(4'd7 - d) * 4 +: 4] = lat_q[(4'd7 - d) * 4 +: 4] | dig;
              if (!it.is_digit) bad_d = 1'b1;
            end else if (comma_q == 5'd3 && k == 4'd0) begin
              north_d = (c == nmeafx_pkg::ChN);
            end else if (comma_q == 5'd4 && k < 4'd10 && k != 4'd5) begin
              d = (k < 4'd5) ? k : k - 4'd1;
              lon_d[(4'd8 - d) * 4 +: 4] = lon_q[(4'd8 - d) * 4 +: 4] | dig;
              if (!it.is_digit) bad_d = 1'b1;
            end else if (comma_q == 5'd5 && k == 4'd0) begin
              east_d = (c == nmeafx_pkg::ChE);
            end else if (comma_q == 5'd9 && k < 4'(nmeafx_pkg::AltitudeChars)) begin
              alt_d[(4'd7 - k) * 8 +: 8] = c;
            end
          end
          nmeafx_pkg::KIND_GSA: begin
            if (comma_q == 5'd15 && k < 4'd6) pdop_d[(4'd5 - k) * 8 +: 8] = c;
          end
          default: ;
        endcase
      end
    end
    valid_fix = (status_q == nmeafx_pkg::ChA) && !bad_q;
  end

  always_comb begin
    ov_d = ov_q;
    o_time_d = o_time_q;  o_date_d = o_date_q;  o_speed_d = o_speed_q;
    o_pdop_d = o_pdop_q;  o_lat_d = o_lat_q;  o_lon_d = o_lon_q;
    o_n_d = o_n_q;  o_e_d = o_e_q;  o_alt_d = o_alt_q;  o_fv_d = o_fv_q;
    o_tn_d = o_tn_q;  o_to_d = o_to_q;
    if (!out_stall) ov_d = 1'b0;
    if (tick) begin
      ov_d = 1'b1;
      o_time_d = '0;  o_date_d = '0;  o_speed_d = '0;  o_pdop_d = '0;
      o_lat_d = '0;  o_lon_d = '0;  o_n_d = 1'b0;  o_e_d = 1'b0;
      o_alt_d = '0;  o_fv_d = 1'b0;  o_tn_d = 1'b0;  o_to_d = to;
    end else if (emit) begin
      ov_d = 1'b1;
      o_time_d  = rejected ? '0 : time_q;
      o_date_d  = rejected ? '0 : date_q;
      o_speed_d = speed_q;
      o_pdop_d  = pdop_q;
      o_lat_d   = valid_fix ? lat_q : '0;
      o_lon_d   = valid_fix ? lon_q : '0;
      o_n_d     = valid_fix && north_q;
      o_e_d     = valid_fix && east_q;
      o_alt_d   = valid_fix ? alt_q : nmeafx_pkg::Zeros8;
      o_fv_d    = valid_fix;
      o_tn_d    = !rejected;
      o_to_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nmeafx_pkg::PH_HUNT_RMC;
      kind_q <= nmeafx_pkg::KIND_NONE;
      hpos_q <= 3'd0;  comma_q <= 5'd0;  cif_q <= 4'd0;
      time_q <= '0;  date_q <= '0;  status_q <= nmeafx_pkg::ChV;
      speed_q <= nmeafx_pkg::Zeros6;  lat_q <= '0;  lon_q <= '0;
      north_q <= 1'b0;  east_q <= 1'b0;  alt_q <= nmeafx_pkg::Zeros8;
      pdop_q <= nmeafx_pkg::Zeros6;  bad_q <= 1'b0;  fix_seen_q <= 1'b0;
      tg_q <= 1'b0;  idle_q <= 4'd0;
      tlimit_q <= 4'd10;  ryear_q <= 7'd80;
      ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d;  kind_q <= kind_d;  hpos_q <= hpos_d;
      comma_q <= comma_d;  cif_q <= cif_d;  time_q <= time_d;
      date_q <= date_d;  status_q <= status_d;  speed_q <= speed_d;
      lat_q <= lat_d;  lon_q <= lon_d;  north_q <= north_d;  east_q <= east_d;
      alt_q <= alt_d;  pdop_q <= pdop_d;  bad_q <= bad_d;
      fix_seen_q <= fix_seen_d;  tg_q <= tg_d;  idle_q <= idle_d;
      ov_q <= ov_d;
      if (cfg_we) begin
        unique case (cfg_idx)
          nmeafx_pkg::CfgTimeoutLimit: tlimit_q <= cfg_data[3:0];
          nmeafx_pkg::CfgRejectYear:   ryear_q <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    o_time_q <= o_time_d;  o_date_q <= o_date_d;  o_speed_q <= o_speed_d;
    o_pdop_q <= o_pdop_d;  o_lat_q <= o_lat_d;  o_lon_q <= o_lon_d;
    o_n_q <= o_n_d;  o_e_q <= o_e_d;  o_alt_q <= o_alt_d;
    o_fv_q <= o_fv_d;  o_tn_q <= o_tn_d;  o_to_q <= o_to_d;
  end

  assign out_valid       = ov_q;
  assign time_bcd_o      = o_time_q;
  assign date_bcd_o      = o_date_q;
  assign speed_text_o    = o_speed_q;
  assign pdop_text_o     = o_pdop_q;
  assign latitude_bcd_o  = o_lat_q;
  assign longitude_bcd_o = o_lon_q;
  assign is_north_o      = o_n_q;
  assign is_east_o       = o_e_q;
  assign altitude_text_o = o_alt_q;
  assign fix_valid_o     = o_fv_q;
  assign time_is_new_o   = o_tn_q;
  assign timed_out_o     = o_to_q;

endmodule

// ===== design/nmea_rmc_gga_gsa_fix_extractor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_gga_gsa_fix_extractor_top
// Items pass through the input queue to the parser, whose records are registered before out_valid.
// Throughput: one item per cycle unless the output stalls while holding a record.
// A two-entry input queue and a registered output let each side stall alone.
// Reset clears parser state, counters, queue and output valid; registers
// return to timeout limit 10 and reject year 80.
// ----------------------------------------------------------------------------
module nmea_rmc_gga_gsa_fix_extractor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [35:0] time_bcd_o,
  output logic [23:0] date_bcd_o,
  output logic [47:0] speed_text_o,
  output logic [47:0] pdop_text_o,
  output logic [31:0] latitude_bcd_o,
  output logic [35:0] longitude_bcd_o,
  output logic        is_north_o,
  output logic        is_east_o,
  output logic [63:0] altitude_text_o,
  output logic        fix_valid_o,
  output logic        time_is_new_o,
  output logic        timed_out_o
);

  nmeafx_pkg::queue_head_t head;
  logic                    pop;

  nmeafx_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode_i   (mode_i),
    .rx_byte_i(rx_byte_i),
    .head_o   (head),
    .pop_i    (pop)
  );

  nmeafx_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .time_bcd_o     (time_bcd_o),
    .date_bcd_o     (date_bcd_o),
    .speed_text_o   (speed_text_o),
    .pdop_text_o    (pdop_text_o),
    .latitude_bcd_o (latitude_bcd_o),
    .longitude_bcd_o(longitude_bcd_o),
    .is_north_o     (is_north_o),
    .is_east_o      (is_east_o),
    .altitude_text_o(altitude_text_o),
    .fix_valid_o    (fix_valid_o),
    .time_is_new_o  (time_is_new_o),
    .timed_out_o    (timed_out_o)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams NMEA sentences, noise and polling ticks into the fix extractor.
// A built-in sentence parser predicts each fix and tick record. Records are
// checked in order under random input gaps, random output stalls and several
// register settings.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic       mode;
    logic [7:0] ch;
  } rx_item_t;

  typedef struct packed {
    logic [35:0] time_bcd;
    logic [23:0] date_bcd;
    logic [47:0] speed_text;
    logic [47:0] pdop_text;
    logic [31:0] latitude_bcd;
    logic [35:0] longitude_bcd;
    logic        is_north;
    logic        is_east;
    logic [63:0] altitude_text;
    logic        fix_valid;
    logic        time_is_new;
    logic        timed_out;
  } fix_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = nmeafx_pkg::CfgTimeoutLimit;
  logic [6:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode_i = 1'b0;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  fix_rec_t    got;

  rx_item_t    tx_bytes[$];
  fix_rec_t    want_recs[$];
  int          n_items, n_records, n_ticks, n_errors, n_cycles;

  // parser state
  nmeafx_pkg::phase_e phase;
  logic [2:0]  hpos;
  nmeafx_pkg::kind_e  kind;
  logic [4:0]  commas;
  logic [3:0]  cif;
  logic [35:0] cap_time;
  logic [23:0] cap_date;
  logic [7:0]  cap_status;
  logic [47:0] cap_speed, cap_pdop;
  logic [31:0] cap_lat;
  logic [35:0] cap_lon;
  logic        cap_north, cap_east, bad, fixed, talker_g;
  logic [63:0] cap_alt;
  logic [3:0]  idle_ticks, lim;
  logic [6:0]  ryear;

  nmea_rmc_gga_gsa_fix_extractor_top DUT (
    .clk_i, .rst_ni, .cfg_we, .cfg_idx, .cfg_data,
    .in_valid, .in_stall, .mode_i, .rx_byte_i,
    .out_valid, .out_stall,
    .time_bcd_o(got.time_bcd), .date_bcd_o(got.date_bcd),
    .speed_text_o(got.speed_text), .pdop_text_o(got.pdop_text),
    .latitude_bcd_o(got.latitude_bcd), .longitude_bcd_o(got.longitude_bcd),
    .is_north_o(got.is_north), .is_east_o(got.is_east),
    .altitude_text_o(got.altitude_text), .fix_valid_o(got.fix_valid),
    .time_is_new_o(got.time_is_new), .timed_out_o(got.timed_out)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [3:0] digit_val(logic [7:0] c, bit strict);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (strict) bad = 1'b1;
    return 4'd0;
  endfunction

  function automatic void parser_clear();
    phase = nmeafx_pkg::PH_HUNT_RMC; hpos = '0; kind = nmeafx_pkg::KIND_NONE;
    commas = '0; cif = '0;
    cap_time = '0; cap_date = '0; cap_status = nmeafx_pkg::ChV;
    cap_speed = nmeafx_pkg::Zeros6;
    cap_lat = '0; cap_lon = '0; cap_north = 0; cap_east = 0;
    cap_alt = nmeafx_pkg::Zeros8;
    cap_pdop = nmeafx_pkg::Zeros6; bad = 0; fixed = 0; talker_g = 0; idle_ticks = '0;
    lim = 4'd10; ryear = 7'd80;
  endfunction

  function automatic void open_sentence();
    case (kind)
      nmeafx_pkg::KIND_RMC: begin
        phase = nmeafx_pkg::PH_WANT_GGA;
        cap_status = nmeafx_pkg::ChV;
      end
      nmeafx_pkg::KIND_GGA: begin
        if (phase == nmeafx_pkg::PH_HUNT_RMC) kind = nmeafx_pkg::KIND_NONE;
        else begin
          phase = nmeafx_pkg::PH_WANT_GGA;
          bad = 0;
        end
      end
      nmeafx_pkg::KIND_GSA:
        if (phase != nmeafx_pkg::PH_WANT_GSA) kind = nmeafx_pkg::KIND_NONE;
      default: ;
    endcase
  endfunction

  function automatic void header_step(logic [7:0] c);
    case (hpos)
      3'd1: talker_g = (c == nmeafx_pkg::ChG);
      3'd3: begin
        if (c == nmeafx_pkg::ChR && talker_g) kind = nmeafx_pkg::KIND_RMC;
        else if (c == nmeafx_pkg::ChG)
          kind = talker_g ? nmeafx_pkg::KIND_GGA : nmeafx_pkg::KIND_GSA;
        else kind = nmeafx_pkg::KIND_NONE;
      end
      3'd4: begin
        if (kind == nmeafx_pkg::KIND_RMC) begin
          if (c != nmeafx_pkg::ChM) kind = nmeafx_pkg::KIND_NONE;
        end else if (kind == nmeafx_pkg::KIND_GGA) begin
          if (c == nmeafx_pkg::ChS) kind = nmeafx_pkg::KIND_GSA;
          else if (c != nmeafx_pkg::ChG) kind = nmeafx_pkg::KIND_NONE;
        end else if (kind == nmeafx_pkg::KIND_GSA) begin
          if (c != nmeafx_pkg::ChS) kind = nmeafx_pkg::KIND_NONE;
        end
      end
      3'd5: begin
        if (kind == nmeafx_pkg::KIND_RMC) begin
          if (c != nmeafx_pkg::ChC) kind = nmeafx_pkg::KIND_NONE;
        end else if (c != nmeafx_pkg::ChA) kind = nmeafx_pkg::KIND_NONE;
      end
      default: ;
    endcase
    if (hpos >= 3'd5) begin
      hpos = '0;
      open_sentence();
    end else hpos++;
  endfunction

  function automatic void field_char(logic [7:0] c);
    int k, d;
    k = cif;
    if (cif < 15) cif++;
    if (kind == nmeafx_pkg::KIND_RMC) begin
      if (commas == 1 && k < 10 && k != 6) begin
        d = k < 6 ? k : k - 1;
        cap_time[(8 - d) * 4 +: 4] |= digit_val(c, 0);
      end else if (commas == 2 && k == 0) cap_status = c;
      else if (commas == 7 && k < 6) cap_speed[(5 - k) * 8 +: 8] = c;
      else if (commas == 9 && k < 6) cap_date[(5 - k) * 4 +: 4] |= digit_val(c, 0);
    end else if (kind == nmeafx_pkg::KIND_GGA) begin
      if (commas == 2 && k < 9 && k != 4) begin
        d = k < 4 ? k : k - 1;
        cap_lat[(7 - d) * 4 +: 4] |= digit_val(c, 1);
      end else if (commas == 3 && k == 0) cap_north = (c == nmeafx_pkg::ChN);
      else if (commas == 4 && k < 10 && k != 5) begin
        d = k < 5 ? k : k - 1;
        cap_lon[(8 - d) * 4 +: 4] |= digit_val(c, 1);
      end else if (commas == 5 && k == 0) cap_east = (c == nmeafx_pkg::ChE);
      else if (commas == 9 && k < nmeafx_pkg::AltitudeChars)
        cap_alt[(7 - k) * 8 +: 8] = c;
    end else if (kind == nmeafx_pkg::KIND_GSA) begin
      if (commas == 15 && k < 6) cap_pdop[(5 - k) * 8 +: 8] = c;
    end
  endfunction

  function automatic fix_rec_t build_fix();
    fix_rec_t r;
    bit rej, ok;
    rej = (cap_date[7:4] * 10 + cap_date[3:0]) == ryear;
    ok = (cap_status == nmeafx_pkg::ChA) && !bad;
    r.time_bcd = rej ? '0 : cap_time;
    r.date_bcd = rej ? '0 : cap_date;
    r.speed_text = cap_speed;
    r.pdop_text = cap_pdop;
    r.latitude_bcd = ok ? cap_lat : '0;
    r.longitude_bcd = ok ? cap_lon : '0;
    r.is_north = ok && cap_north;
    r.is_east = ok && cap_east;
    r.altitude_text = ok ? cap_alt : nmeafx_pkg::Zeros8;
    r.fix_valid = ok;
    r.time_is_new = !rej;
    r.timed_out = 1'b0;
    phase = nmeafx_pkg::PH_HUNT_RMC;
    fixed = 1;
    idle_ticks = '0;
    return r;
  endfunction

  function automatic void comma_step();
    int closed;
    closed = cif;
    if (kind == nmeafx_pkg::KIND_GGA) begin
      if (commas == 2 && closed < 9) bad = 1;
      if (commas == 4 && closed < 10) bad = 1;
    end
    if (commas < 31) commas++;
    cif = '0;
    if (kind == nmeafx_pkg::KIND_RMC) begin
      if (commas == 1) cap_time = '0;
      else if (commas == 2) cap_status = nmeafx_pkg::ChV;
      else if (commas == 7) cap_speed = nmeafx_pkg::Zeros6;
      else if (commas == 9) cap_date = '0;
    end else if (kind == nmeafx_pkg::KIND_GGA) begin
      if (commas == 2) cap_lat = '0;
      else if (commas == 3) cap_north = 0;
      else if (commas == 4) cap_lon = '0;
      else if (commas == 5) cap_east = 0;
      else if (commas == 9) cap_alt = nmeafx_pkg::Zeros8;
      else if (commas == 14) begin
        phase = nmeafx_pkg::PH_WANT_GSA;
        kind = nmeafx_pkg::KIND_NONE;
      end
    end else if (kind == nmeafx_pkg::KIND_GSA) begin
      if (commas == 15) cap_pdop = nmeafx_pkg::Zeros6;
      else if (commas == 16) begin
        kind = nmeafx_pkg::KIND_NONE;
        if (closed > 0) begin
          want_recs.push_back(build_fix());
          n_records++;
        end else phase = nmeafx_pkg::PH_HUNT_RMC;
      end
    end
  endfunction

  function automatic void parse_item(rx_item_t it);
    fix_rec_t r;
    if (it.mode) begin
      if (fixed) idle_ticks = '0;
      else if (idle_ticks < 15) idle_ticks++;
      fixed = 0;
      r = '0;
      r.timed_out = idle_ticks >= lim;
      if (r.timed_out) cap_status = nmeafx_pkg::ChV;
      want_recs.push_back(r);
      n_ticks++;
    end else if (it.ch == nmeafx_pkg::ChDollar) begin
      hpos = 3'd1; kind = nmeafx_pkg::KIND_NONE; commas = '0; cif = '0; talker_g = 0;
    end else if (hpos != 0) header_step(it.ch);
    else if (kind != nmeafx_pkg::KIND_NONE) begin
      if (it.ch == nmeafx_pkg::ChComma) comma_step();
      else field_char(it.ch);
    end
  endfunction

  function automatic bit calm();
    return n_cycles > 600 && n_cycles < 1000;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    rx_item_t it;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      n_cycles++;
      if (in_valid && !in_stall) begin
        parse_item('{mode_i, rx_byte_i});
        n_items++;
      end
      if (!(in_valid && in_stall)) begin
        if (tx_bytes.size() != 0 && (calm() || $urandom_range(99) >= 22)) begin
          it = tx_bytes.pop_front();
          in_valid <= 1'b1;
          mode_i <= it.mode;
          rx_byte_i <= it.mode ? 8'($urandom) : it.ch;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    fix_rec_t w;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_recs.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected record %p", got);
        end else begin
          w = want_recs.pop_front();
          if (got !== w) begin
            n_errors++;
            if (n_errors <= 10) $display("mismatch\n  exp %p\n  got %p", w, got);
          end
        end
      end
      out_stall <= !calm() && $urandom_range(99) < 22;
    end
  end

  task automatic put_text(string s);
    foreach (s[i]) tx_bytes.push_back('{1'b0, s[i]});
  endtask

  task automatic put_tick();
    tx_bytes.push_back('{1'b1, 8'h00});
  endtask

  task automatic put_digits(int n, int bad_pct);
    repeat (n) begin
      if ($urandom_range(99) < bad_pct) tx_bytes.push_back('{1'b0, 8'($urandom_range(32, 126))});
      else tx_bytes.push_back('{1'b0, 8'("0" + $urandom_range(9))});
    end
  endtask

  task automatic put_rmc();
    int r;
    put_text($urandom_range(9) == 0 ? "$BDRMC," : "$GPRMC,");
    put_digits($urandom_range(9) == 0 ? $urandom_range(8) : 6, 5);
    put_text(".");
    put_digits($urandom_range(4), 5);
    r = $urandom_range(9);
    put_text(r < 7 ? ",A," : (r < 9 ? ",V," : ",,"));
    put_text("4807.038,N,01131.000,E,");
    put_digits($urandom_range(3), 0);
    put_text($urandom_range(1) ? ".4" : "");
    put_digits($urandom_range(4), 10);
    put_text(",084.4,");
    put_digits(4, 3);
    if ($urandom_range(3) == 0) put_text($sformatf("%02d", ryear));
    else put_digits($urandom_range(3), 10);
    put_text(",003.1,W*6A\r\n");
  endtask

  task automatic put_gga();
    put_text($urandom_range(9) == 0 ? "$GNGGA,123519," : "$GPGGA,123519,");
    put_digits($urandom_range(9) == 0 ? $urandom_range(5) : 4, 3);
    put_text(".");
    put_digits($urandom_range(9) == 0 ? $urandom_range(5) : 4, 3);
    put_text($urandom_range(1) ? ",N," : ",S,");
    put_digits($urandom_range(9) == 0 ? $urandom_range(6) : 5, 3);
    put_text(".");
    put_digits($urandom_range(9) == 0 ? $urandom_range(5) : 4, 3);
    put_text($urandom_range(1) ? ",E," : ",W,");
    put_text("1,08,0.9,");
    put_digits($urandom_range(10), 15);
    put_text(",M,46.9,M,,*47\r\n");
  endtask

  task automatic put_gsa();
    int r;
    r = $urandom_range(3);
    put_text(r == 0 ? "$BDGSA,A,3," : (r == 1 ? "$GNGSA,A,3," : "$GPGSA,A,3,"));
    repeat (12) begin
      put_digits($urandom_range(2), 0);
      put_text(",");
    end
    if ($urandom_range(6) != 0) put_digits($urandom_range(1, 8), 15);
    put_text(",2.1,1.8*39\r\n");
  endtask

  task automatic put_noise();
    repeat ($urandom_range(1, 12)) tx_bytes.push_back('{1'b0, 8'($urandom)});
  endtask

  task automatic put_group();
    int r;
    r = $urandom_range(99);
    if (r < 65) begin
      put_rmc();
      if ($urandom_range(9) == 0) put_tick();
      put_gga();
      if ($urandom_range(9) == 0) put_gga();
      put_gsa();
    end else if (r < 78) begin
      case ($urandom_range(3))
        0: put_gsa();
        1: put_gga();
        2: begin put_rmc(); put_gsa(); end
        default: begin put_rmc(); put_gga(); put_noise(); put_gsa(); end
      endcase
    end else if (r < 88) put_noise();
    else repeat ($urandom_range(1, 17)) put_tick();
    if ($urandom_range(4) == 0) put_tick();
  endtask

  task automatic set_regs(logic [3:0] limit_val, logic [6:0] year_val);
    wait (tx_bytes.size() == 0 && !in_valid && want_recs.size() == 0);
    repeat (8) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= nmeafx_pkg::CfgTimeoutLimit;
    cfg_data <= 7'(limit_val);
    @(posedge clk_i);
    cfg_idx <= nmeafx_pkg::CfgRejectYear;
    cfg_data <= year_val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    lim = limit_val;
    ryear = year_val;
  endtask

  initial begin
    parser_clear();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: rejected year, empty pdop, out-of-order sentences, timeouts
    put_tick();
    put_text("$GPRMC,235959.999,A,,,,,123.4567,,311280,\r\n");
    put_text("$GPGGA,,9959.9999,N,17959.9999,E,1,,,12345.6789,M,,,,\r\n");
    put_text("$GPGSA,A,3,,,,,,,,,,,,,99.999,\r\n");
    put_text("$GPGSA,A,3,,,,,,,,,,,,,1.0,\r\n");
    put_text("$GPRMC,000000.000,,,,,,,,000101,\r\n$GPGGA,,48x7.038,N,0113.1,W,,,,,,,,,\r\n");
    put_text("$GPGSA,A,3,,,,,,,,,,,,,,,\r\n");
    repeat (16) put_tick();
    set_regs(4'd1, 7'd0);
    for (int p = 0; p < 5; p++) begin
      put_group();
      case (p)
        0: set_regs(4'd15, 7'd99);
        1: set_regs(4'($urandom_range(1, 15)), 7'($urandom_range(99)));
        2: set_regs(4'd10, 7'd80);
        3: set_regs(4'($urandom_range(1, 15)), 7'($urandom_range(99)));
        default: ;
      endcase
    end
    wait (tx_bytes.size() == 0 && !in_valid && want_recs.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("sent %0d items: %0d fix records and %0d tick records checked, %0d errors",
             n_items, n_records, n_ticks, n_errors);
    if (n_errors == 0 && want_recs.size() == 0) begin
      $display("[nmea_rmc_gga_gsa_fix_extractor_top] OK");
    end else begin
      $display("[nmea_rmc_gga_gsa_fix_extractor_top] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("[nmea_rmc_gga_gsa_fix_extractor_top] ERROR");
    $finish;
  end

endmodule

// ===== nmea_rmc_gga_gsa_fix_extractor_top.f =====
design/nmeafx_pkg.sv
design/nmeafx_front.sv
design/nmeafx_back.sv
design/nmea_rmc_gga_gsa_fix_extractor_top.sv
test/tb.sv
